// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the timer slot table.
// Clocked property checks; they compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_CLK_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NR(label, clk, prop)
`endif
`endif

// ===== rtl/ostst_pkg.sv =====
// Package of the one-shot timer slot table: sizes, codes and payload layouts.
// No dependencies; used by the top level by scoped names.
package ostst_pkg;

   localparam int SLOTS = 32;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam int REQ_DATA_W = 232;
   localparam int RSP_DATA_W = 120;
   localparam int USER_W     = 2;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [5:0]       cnt_fld_type;

   typedef enum logic [1:0] {
      OP_SCHED  = 2'd0,
      OP_CANCEL = 2'd1,
      OP_RUN    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_SCHED   = 2'd0,
      KIND_CANCEL  = 2'd1,
      KIND_FIRED   = 2'd2,
      KIND_SUMMARY = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_INVALID   = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   // packed structs: last member sits in the lowest bits
   typedef struct packed {
      logic [63:0] now_time;
      logic [63:0] cancel_id;
      logic [31:0] user_tag;
      logic [7:0]  handler;
      logic [63:0] due_time;
   } req_data_type;

   typedef struct packed {
      logic [1:0]  pad;
      cnt_fld_type pending_count;
      cnt_fld_type fire_count;
      logic [31:0] fired_tag;
      logic [7:0]  fired_handler;
      logic [63:0] timer_id;
      status_type  status;
   } rsp_data_type;

   typedef struct packed {
      logic [63:0] id;
      logic [63:0] due;
      logic [7:0]  handler;
      logic [31:0] tag;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

endpackage

// ===== rtl/one_shot_timer_slot_table.sv =====
// One-shot timer slot table: one shared compare unit walks the slot RAM per op.
// Depends on ostst_pkg, ostst_ram and assert_macros.svh.
//
// Usage: one op per req transfer (tuser selects schedule, cancel or run).
// Each op produces its results on the rsp channel, the final one with tlast.
// Schedule and cancel return one reply; run returns one transfer per fired
// timer (ascending slot order) and then a summary with the fire count.
// Timing: the sequencer reads one slot per cycle from the slot RAM, unless a
// firing waits for the output register, and feeds it to a single 64-bit
// compare unit. A schedule stops at the first free slot and a cancel at the
// matching slot; a run or a miss scans every slot before its final result.
// Rejected arguments give their reply without a scan. The next op is taken the
// cycle after the final result is loaded into the output register, which may
// still wait to be taken.
// When the receiver stalls, the scan holds on the pending firing and resumes
// without loss. Reset empties all slots, sets the id counter to 1 and the
// pending count to 0; slot payloads need no clearing.
`include "assert_macros.svh"

module one_shot_timer_slot_table (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // due_time[63:0], handler[71:64], user_tag[103:72], cancel_id[167:104],
   // now_time[231:168]
   input  logic [231:0] req_tdata,
   // op[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], timer_id[65:2], fired_handler[73:66], fired_tag[105:74],
   // fire_count[111:106], pending_count[117:112], zero[119:118]
   output logic [119:0] rsp_tdata,
   // kind[1:0]
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                  state_ff, state_in;
   ostst_pkg::op_type          op_ff, op_in;
   logic [63:0]                key_ff, key_in;
   logic [63:0]                due_ff, due_in;
   logic [7:0]                 hnd_ff, hnd_in;
   logic [31:0]                tag_ff, tag_in;
   ostst_pkg::cnt_type         scan_idx_ff, scan_idx_in;
   logic                       chk_vld_ff, chk_vld_in;
   ostst_pkg::idx_type         chk_idx_ff, chk_idx_in;
   ostst_pkg::cnt_type         fire_cnt_ff, fire_cnt_in;
   ostst_pkg::cnt_type         pending_ff, pending_in;
   logic [63:0]                id_counter_ff, id_counter_in;
   logic [ostst_pkg::SLOTS-1:0] active_ff, active_in;
   ostst_pkg::status_type      fin_status_ff, fin_status_in;
   logic [63:0]                fin_id_ff, fin_id_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   ostst_pkg::kind_type        rsp_user_ff, rsp_user_in;
   ostst_pkg::rsp_data_type    rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;

   ostst_pkg::req_data_type    req_data;
   ostst_pkg::slot_type        rd_slot;
   ostst_pkg::slot_type        wr_slot;
   logic [ostst_pkg::SLOT_W-1:0] ram_rd_data;
   logic                       ram_wr_en;
   logic                       ram_rd_en;
   logic [63:0]                cmp_a;
   logic                       cmp_eq;
   logic                       cmp_le;
   logic                       chk_active;
   logic                       hit;
   logic                       fire;
   logic                       out_free;
   ostst_pkg::cnt_type         pend_dec;

   assign req_data   = ostst_pkg::req_data_type'(req_tdata);
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign pend_dec   = pending_ff - ostst_pkg::cnt_type'(1);

   assign wr_slot.id      = id_counter_ff;
   assign wr_slot.due     = due_ff;
   assign wr_slot.handler = hnd_ff;
   assign wr_slot.tag     = tag_ff;

   ostst_ram #(
      .WIDTH (ostst_pkg::SLOT_W),
      .DEPTH (ostst_pkg::SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (chk_idx_ff),
      .wr_data (wr_slot),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_idx_ff[ostst_pkg::IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // shared compare unit: id match for cancel, due check for run
   assign rd_slot    = ostst_pkg::slot_type'(ram_rd_data);
   assign cmp_a      = (op_ff == ostst_pkg::OP_CANCEL) ? rd_slot.id : rd_slot.due;
   assign cmp_eq     = (cmp_a == key_ff);
   assign cmp_le     = (cmp_a <= key_ff);
   assign chk_active = active_ff[chk_idx_ff];

   always_comb begin
      unique case (op_ff)
         ostst_pkg::OP_SCHED:  hit = !chk_active;
         ostst_pkg::OP_CANCEL: hit = chk_active && cmp_eq;
         ostst_pkg::OP_RUN:    hit = chk_active && cmp_le;
         default:              hit = 1'b0;
      endcase
   end

   assign fire = (state_ff == ST_SCAN) && chk_vld_ff && hit && (op_ff == ostst_pkg::OP_RUN);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      due_in        = due_ff;
      hnd_in        = hnd_ff;
      tag_in        = tag_ff;
      scan_idx_in   = scan_idx_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      fire_cnt_in   = fire_cnt_ff;
      pending_in    = pending_ff;
      id_counter_in = id_counter_ff;
      active_in     = active_ff;
      fin_status_in = fin_status_ff;
      fin_id_in     = fin_id_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_user_in   = rsp_user_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            chk_vld_in = 1'b0;
            if (req_tvalid) begin
               op_in         = ostst_pkg::op_type'(req_tuser);
               key_in        = (ostst_pkg::op_type'(req_tuser) == ostst_pkg::OP_CANCEL) ?
                               req_data.cancel_id : req_data.now_time;
               due_in        = req_data.due_time;
               hnd_in        = req_data.handler;
               tag_in        = req_data.user_tag;
               scan_idx_in   = '0;
               fire_cnt_in   = '0;
               fin_id_in     = '0;
               fin_status_in = ostst_pkg::STAT_OK;
               unique case (ostst_pkg::op_type'(req_tuser))
                  ostst_pkg::OP_SCHED: begin
                     if (req_data.handler == 8'd0) begin
                        fin_status_in = ostst_pkg::STAT_INVALID;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  ostst_pkg::OP_CANCEL: begin
                     if (req_data.cancel_id == 64'd0) begin
                        fin_status_in = ostst_pkg::STAT_INVALID;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  ostst_pkg::OP_RUN: state_in = ST_SCAN;
                  default: ;  // drop the unused op code
               endcase
            end
         end

         ST_SCAN: begin
            // hold the whole pipe while a firing waits for the output register
            if (!(fire && !out_free)) begin
               if (chk_vld_ff && hit && (op_ff != ostst_pkg::OP_RUN)) begin
                  state_in      = ST_DONE;
                  chk_vld_in    = 1'b0;
                  fin_status_in = ostst_pkg::STAT_OK;
                  if (op_ff == ostst_pkg::OP_SCHED) begin
                     ram_wr_en             = 1'b1;
                     active_in[chk_idx_ff] = 1'b1;
                     id_counter_in         = id_counter_ff + 64'd1;
                     pending_in            = pending_ff + ostst_pkg::cnt_type'(1);
                     fin_id_in             = id_counter_ff;
                  end else begin
                     active_in[chk_idx_ff] = 1'b0;
                     pending_in            = pend_dec;
                  end
               end else if (scan_idx_ff < ostst_pkg::cnt_type'(ostst_pkg::SLOTS)) begin
                  ram_rd_en   = 1'b1;
                  chk_vld_in  = 1'b1;
                  chk_idx_in  = scan_idx_ff[ostst_pkg::IDX_W-1:0];
                  scan_idx_in = scan_idx_ff + ostst_pkg::cnt_type'(1);
               end else begin
                  chk_vld_in = 1'b0;
                  if (!chk_vld_ff) begin
                     state_in = ST_DONE;
                     unique case (op_ff)
                        ostst_pkg::OP_SCHED:  fin_status_in = ostst_pkg::STAT_FULL;
                        ostst_pkg::OP_CANCEL: fin_status_in = ostst_pkg::STAT_NOT_FOUND;
                        default:              fin_status_in = ostst_pkg::STAT_OK;
                     endcase
                  end
               end

               if (fire) begin
                  active_in[chk_idx_ff]     = 1'b0;
                  pending_in                = pend_dec;
                  fire_cnt_in               = fire_cnt_ff + ostst_pkg::cnt_type'(1);
                  rsp_valid_in              = 1'b1;
                  rsp_user_in               = ostst_pkg::KIND_FIRED;
                  rsp_last_in               = 1'b0;
                  rsp_data_in.pad           = '0;
                  rsp_data_in.status        = ostst_pkg::STAT_OK;
                  rsp_data_in.timer_id      = rd_slot.id;
                  rsp_data_in.fired_handler = rd_slot.handler;
                  rsp_data_in.fired_tag     = rd_slot.tag;
                  rsp_data_in.fire_count    = '0;
                  rsp_data_in.pending_count = ostst_pkg::cnt_fld_type'(pend_dec);
               end
            end
         end

         ST_DONE: begin
            if (out_free) begin
               state_in                  = ST_IDLE;
               rsp_valid_in              = 1'b1;
               rsp_last_in               = 1'b1;
               rsp_data_in.pad           = '0;
               rsp_data_in.status        = fin_status_ff;
               rsp_data_in.timer_id      = fin_id_ff;
               rsp_data_in.fired_handler = '0;
               rsp_data_in.fired_tag     = '0;
               rsp_data_in.fire_count    = '0;
               rsp_data_in.pending_count = ostst_pkg::cnt_fld_type'(pending_ff);
               unique case (op_ff)
                  ostst_pkg::OP_SCHED:  rsp_user_in = ostst_pkg::KIND_SCHED;
                  ostst_pkg::OP_CANCEL: rsp_user_in = ostst_pkg::KIND_CANCEL;
                  default: begin
                     rsp_user_in            = ostst_pkg::KIND_SUMMARY;
                     rsp_data_in.fire_count = ostst_pkg::cnt_fld_type'(fire_cnt_ff);
                  end
               endcase
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chk_vld_ff    <= 1'b0;
         fire_cnt_ff   <= '0;
         pending_ff    <= '0;
         id_counter_ff <= 64'd1;
         active_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chk_vld_ff    <= chk_vld_in;
         fire_cnt_ff   <= fire_cnt_in;
         pending_ff    <= pending_in;
         id_counter_ff <= id_counter_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      due_ff        <= due_in;
      hnd_ff        <= hnd_in;
      tag_ff        <= tag_in;
      scan_idx_ff   <= scan_idx_in;
      chk_idx_ff    <= chk_idx_in;
      fin_status_ff <= fin_status_in;
      fin_id_ff     <= fin_id_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_CLK(a_pending_matches_active, clock, reset, pending_ff == ostst_pkg::cnt_type'($countones(active_ff)))
   `ASSERT_CLK(a_idle_pipe_drained, clock, reset, (state_ff == ST_IDLE) |-> !chk_vld_ff)
   `ASSERT_CLK(a_fire_count_bounded, clock, reset, fire_cnt_ff <= ostst_pkg::cnt_type'(ostst_pkg::SLOTS))
   `ASSERT_CLK(a_fired_never_last, clock, reset, (rsp_valid_ff && rsp_last_ff) |-> (rsp_user_ff != ostst_pkg::KIND_FIRED))

endmodule

// ===== rtl/ostst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Self-contained; read data holds while the read enable is low.
module ostst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/tb_one_shot_timer_slot_table.sv =====
// Self-checking bench for the one-shot timer slot table: schedule, cancel and run ops
// go through a table predictor that lives in the bench; every reply is checked field by field.
// Depends on ostst_pkg and the one_shot_timer_slot_table RTL.
module tb_one_shot_timer_slot_table;

   localparam logic [1:0]  OP_UNUSED  = 2'd3;
   localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int          CYCLE_CAP  = 1000000;
   localparam int          TAIL_WAIT  = 3 * ostst_pkg::SLOTS;

   typedef struct {
      ostst_pkg::kind_type   kind;
      ostst_pkg::status_type status;
      logic [63:0] id;
      logic [7:0]  hnd;
      logic [31:0] tag;
      logic [5:0]  fired;
      logic [5:0]  pend;
      logic        last;
   } timer_reply_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [231:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;

   // table copy held by the bench
   bit          slot_live [ostst_pkg::SLOTS];
   logic [63:0] slot_ident [ostst_pkg::SLOTS];
   logic [63:0] slot_deadline [ostst_pkg::SLOTS];
   logic [7:0]  slot_hnd [ostst_pkg::SLOTS];
   logic [31:0] slot_cookie [ostst_pkg::SLOTS];
   logic [63:0] next_id = 64'd1;
   int          live_count = 0;

   timer_reply_type awaited_replies [$];
   logic [63:0]     issued_ids [$];

   bit quiet = 1'b0;
   int mismatches = 0;
   int items_sent = 0;
   int replies_seen = 0;
   int timers_fired = 0;
   int full_rejects = 0;
   int cycle_count = 0;
   int stall_left = 0;

   one_shot_timer_slot_table uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void push_reply(ostst_pkg::kind_type kind, ostst_pkg::status_type status,
                                      logic [63:0] id, logic [7:0] hnd, logic [31:0] tag,
                                      int fired, bit last);
      timer_reply_type t;
      t.kind   = kind;
      t.status = status;
      t.id     = id;
      t.hnd    = hnd;
      t.tag    = tag;
      t.fired  = fired[5:0];
      t.pend   = live_count[5:0];
      t.last   = last;
      awaited_replies.push_back(t);
   endfunction

   // Apply one accepted op to the bench table and queue the replies it causes.
   function automatic void apply_timer_op(logic [1:0] op, ostst_pkg::req_data_type d);
      int n;
      int slot;
      n = 0;
      slot = -1;
      if (op == ostst_pkg::OP_SCHED) begin
         if (d.handler == 8'd0) begin
            push_reply(ostst_pkg::KIND_SCHED, ostst_pkg::STAT_INVALID, '0, '0, '0, 0, 1'b1);
         end else begin
            for (int i = 0; i < ostst_pkg::SLOTS; i++)
               if (!slot_live[i] && slot < 0) slot = i;
            if (slot < 0) begin
               full_rejects++;
               push_reply(ostst_pkg::KIND_SCHED, ostst_pkg::STAT_FULL, '0, '0, '0, 0, 1'b1);
            end else begin
               slot_live[slot]     = 1'b1;
               slot_ident[slot]    = next_id;
               slot_deadline[slot] = d.due_time;
               slot_hnd[slot]      = d.handler;
               slot_cookie[slot]   = d.user_tag;
               live_count++;
               issued_ids.push_back(next_id);
               push_reply(ostst_pkg::KIND_SCHED, ostst_pkg::STAT_OK, next_id, '0, '0, 0, 1'b1);
               next_id = next_id + 64'd1;
            end
         end
      end else if (op == ostst_pkg::OP_CANCEL) begin
         if (d.cancel_id == 64'd0) begin
            push_reply(ostst_pkg::KIND_CANCEL, ostst_pkg::STAT_INVALID, '0, '0, '0, 0, 1'b1);
         end else begin
            for (int i = 0; i < ostst_pkg::SLOTS; i++)
               if (slot_live[i] && slot_ident[i] == d.cancel_id && slot < 0) slot = i;
            if (slot < 0) begin
               push_reply(ostst_pkg::KIND_CANCEL, ostst_pkg::STAT_NOT_FOUND, '0, '0, '0, 0,
                          1'b1);
            end else begin
               slot_live[slot] = 1'b0;
               live_count--;
               push_reply(ostst_pkg::KIND_CANCEL, ostst_pkg::STAT_OK, '0, '0, '0, 0, 1'b1);
            end
         end
      end else if (op == ostst_pkg::OP_RUN) begin
         for (int i = 0; i < ostst_pkg::SLOTS; i++) begin
            if (slot_live[i] && slot_deadline[i] <= d.now_time) begin
               slot_live[i] = 1'b0;
               live_count--;
               n++;
               push_reply(ostst_pkg::KIND_FIRED, ostst_pkg::STAT_OK, slot_ident[i], slot_hnd[i],
                          slot_cookie[i], 0, 1'b0);
            end
         end
         timers_fired += n;
         push_reply(ostst_pkg::KIND_SUMMARY, ostst_pkg::STAT_OK, '0, '0, '0, n, 1'b1);
      end
      // op 3 is dropped by the block and leaves no reply
   endfunction

   // Present one op, hold it until the transfer, then open the gap before the next one.
   task automatic send_timer_op(logic [1:0] op, ostst_pkg::req_data_type d);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_timer_op(op, d);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic do_schedule(logic [63:0] due, logic [7:0] hnd, logic [31:0] tag);
      ostst_pkg::req_data_type d;
      d = '0;
      d.due_time = due;
      d.handler  = hnd;
      d.user_tag = tag;
      send_timer_op(ostst_pkg::OP_SCHED, d);
   endtask

   task automatic do_cancel(logic [63:0] id);
      ostst_pkg::req_data_type d;
      d = '0;
      d.cancel_id = id;
      send_timer_op(ostst_pkg::OP_CANCEL, d);
   endtask

   task automatic do_run(logic [63:0] now);
      ostst_pkg::req_data_type d;
      d = '0;
      d.now_time = now;
      send_timer_op(ostst_pkg::OP_RUN, d);
   endtask

   // Drop valid and hold the sender until every queued reply has come back.
   task automatic drain_replies();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("mismatch on %s at reply %0d: got %0h, want %0h", what, replies_seen, got,
               want);
   endtask

   task automatic check_reply();
      ostst_pkg::rsp_data_type got;
      timer_reply_type want;
      got = rsp_tdata;
      replies_seen++;
      if (awaited_replies.size() == 0) begin
         report_mismatch("unexpected reply kind", 64'(rsp_tuser), '0);
      end else begin
         want = awaited_replies.pop_front();
         if (rsp_tuser !== want.kind)
            report_mismatch("kind", 64'(rsp_tuser), 64'(want.kind));
         if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
         if (got.timer_id !== want.id) report_mismatch("timer_id", got.timer_id, want.id);
         if (got.fired_handler !== want.hnd)
            report_mismatch("fired_handler", 64'(got.fired_handler), 64'(want.hnd));
         if (got.fired_tag !== want.tag)
            report_mismatch("fired_tag", 64'(got.fired_tag), 64'(want.tag));
         if (got.fire_count !== want.fired)
            report_mismatch("fire_count", 64'(got.fire_count), 64'(want.fired));
         if (got.pending_count !== want.pend)
            report_mismatch("pending_count", 64'(got.pending_count), 64'(want.pend));
         if (rsp_tlast !== want.last)
            report_mismatch("last", 64'(rsp_tlast), 64'(want.last));
         if (got.pad !== 2'b00) report_mismatch("padding", 64'(got.pad), '0);
      end
   endtask

   // Sample the reply channel and pick the next ready value with random stalls.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) check_reply();
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap();
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
                  awaited_replies.size());
         $display("FAILURE");
         $finish;
      end
   end

   task automatic test_single_ops();
      ostst_pkg::req_data_type d;
      do_run(rand64());
      do_cancel(64'd0);
      do_cancel(ALL_ONES);
      do_schedule(64'd12, 8'd0, 32'h1234_5678);
      do_schedule(64'd0, 8'd1, 32'd0);
      do_schedule(ALL_ONES, 8'hFF, 32'hFFFF_FFFF);
      do_schedule(64'd1000, 8'h5A, 32'hA5A5_5A5A);
      do_schedule(64'd1000, 8'd7, 32'h0000_0001);
      do_cancel(64'd3);
      do_cancel(64'd3);
      // unused op code with every field set: must be dropped
      d = '1;
      send_timer_op(OP_UNUSED, d);
      do_run(64'd0);
      do_run(64'd999);
      do_run(64'd1000);
      do_schedule(64'd5, 8'd2, 32'hDEAD_BEEF);
      do_run(ALL_ONES);
      do_cancel(64'd2);
      drain_replies();
   endtask

   task automatic test_table_full();
      logic [63:0] victim;
      while (live_count < ostst_pkg::SLOTS)
         do_schedule(rand64() >> 1, 8'($urandom_range(1, 255)), $urandom);
      do_schedule(rand64(), 8'($urandom_range(1, 255)), $urandom);
      do_schedule(rand64(), 8'd0, $urandom);
      victim = slot_ident[ostst_pkg::SLOTS / 2];
      do_cancel(victim);
      // the freed middle slot must be the one reused
      do_schedule(64'd0, 8'hC3, $urandom);
      do_cancel(victim);
      do_run(ALL_ONES);
      do_run(ALL_ONES);
      drain_replies();
   endtask

   function automatic logic [63:0] pick_cancel_id();
      int r;
      int live_idx [$];
      r = $urandom_range(0, 99);
      for (int i = 0; i < ostst_pkg::SLOTS; i++)
         if (slot_live[i]) live_idx.push_back(i);
      if (r < 60 && live_idx.size() > 0)
         return slot_ident[live_idx[$urandom_range(0, live_idx.size() - 1)]];
      if (r < 78 && issued_ids.size() > 0)
         return issued_ids[$urandom_range(0, issued_ids.size() - 1)];
      if (r < 88) return 64'd0;
      return rand64();
   endfunction

   function automatic logic [63:0] pick_now();
      int r;
      int live_idx [$];
      r = $urandom_range(0, 99);
      for (int i = 0; i < ostst_pkg::SLOTS; i++)
         if (slot_live[i]) live_idx.push_back(i);
      if (r < 55 && live_idx.size() > 0)
         return slot_deadline[live_idx[$urandom_range(0, live_idx.size() - 1)]];
      if (r < 65) return 64'd0;
      if (r < 72) return ALL_ONES;
      return rand64();
   endfunction

   task automatic test_random_mix(int count);
      ostst_pkg::req_data_type d;
      int r;
      logic [1:0] op;
      for (int k = 0; k < count; k++) begin
         // unused fields carry noise; the block must ignore them
         d.due_time  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 4000)) : rand64();
         d.handler   = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom);
         d.user_tag  = $urandom;
         d.cancel_id = rand64();
         d.now_time  = rand64();
         r = $urandom_range(0, 99);
         if (r < 45) begin
            op = ostst_pkg::OP_SCHED;
         end else if (r < 70) begin
            op = ostst_pkg::OP_CANCEL;
            d.cancel_id = pick_cancel_id();
         end else if (r < 96) begin
            op = ostst_pkg::OP_RUN;
            d.now_time = pick_now();
         end else begin
            op = OP_UNUSED;
         end
         send_timer_op(op, d);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_single_ops();
      test_table_full();
      test_random_mix(20);
      drain_replies();
      quiet = 1'b1;
      test_random_mix(15);
      drain_replies();
      quiet = 1'b0;
      test_random_mix(20);
      drain_replies();
      repeat (TAIL_WAIT) @(posedge clock);
      $display("covered %0d ops and %0d replies: %0d timers fired, %0d full-table rejects",
               items_sent, replies_seen, timers_fired, full_rejects);
      $display("directed edge cases, a full table, and random mixes with and without stalls");
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ostst_pkg.sv
rtl/ostst_ram.sv
rtl/one_shot_timer_slot_table.sv
tb/tb_one_shot_timer_slot_table.sv
